// ===== rtl/core/epr_pkg.sv =====
// shared types and constants of the elevation profile record framer
package epr_pkg;

    localparam int ROWS_W       = 13;
    localparam int MAX_ROWS_DEF = 4096;
    localparam int ROWS_RESET   = 1201;
    localparam int Q_DEPTH      = 2;
    localparam int PADDR_W      = 3;

    localparam logic [7:0] HDR_SYNC  = 8'haa;
    localparam logic [7:0] HDR_ZERO  = 8'h00;
    localparam logic [7:0] SIGN_BIT  = 8'h80;
    localparam logic [7:0] MAG_HI_MASK = 8'h7f;

    // register index, taken from paddr[2]
    localparam logic REG_ROWS_IN_USE = 1'b0;

    typedef struct packed {
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic [15:0] column;
        logic        first;
        logic        last;
    } t_entry;

endpackage

// ===== rtl/core/elevation_profile_record_framer.sv =====
// top level of the elevation profile record framer
// Each signed 16-bit sample on the slave stream leaves as two sign-magnitude
// bytes on the byte-wide master stream, high byte first; the first sample of
// a profile is preceded by an 8-byte header (0xaa, 0, column twice, 0, 0) and
// the last one, set by rows_in_use, is followed by the 32-bit byte sum of the
// record, most significant byte first, with tlast on its final byte. The
// byte-wide output port sets the rate. A two-entry queue between the sample
// front end and the byte sequencer lets intake run ahead of a stalled output;
// a taken sample is written into the queue, and its first byte then passes
// through the registered output stage.
module elevation_profile_record_framer #(
    parameter int MAX_ROWS = epr_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,   // sample, column_index
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,   // out_byte
    output logic                        o_m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [epr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import epr_pkg::*;

    logic [ROWS_W-1:0] r_rows;
    logic              push;
    logic              full;
    logic              pop;
    logic              q_valid;
    t_entry            push_entry;
    t_entry            head_entry;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROWS_IN_USE) ? 32'(r_rows) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_W'(ROWS_RESET);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ROWS_IN_USE) begin
            r_rows <= pwdata[ROWS_W-1:0];
        end
    end

    epr_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_sample (i_s_axis_tdata[15:0]),
        .i_column (i_s_axis_tdata[31:16]),
        .i_rows   (r_rows),
        .i_full   (full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    epr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    epr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_entry   (head_entry),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_byte    (o_m_axis_tdata),
        .o_last    (o_m_axis_tlast)
    );

endmodule

// ===== rtl/core/epr_front.sv =====
// front end: takes samples, tracks profile position, forms sign-magnitude bytes
module epr_front #(
    parameter int MAX_ROWS = epr_pkg::MAX_ROWS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_sample,
    input  logic [15:0]                i_column,
    input  logic [epr_pkg::ROWS_W-1:0] i_rows,
    input  logic                       i_full,
    output logic                       o_push,
    output epr_pkg::t_entry            o_entry
);
    import epr_pkg::*;

    localparam int RowsBits = $clog2(MAX_ROWS + 1);
    localparam int CmpW     = (RowsBits > ROWS_W) ? RowsBits : ROWS_W;

    logic [ROWS_W-1:0] r_pos;
    logic [ROWS_W-1:0] n_pos;
    logic [ROWS_W-1:0] pos_inc;
    logic [CmpW-1:0]   rows_ext;
    logic [CmpW-1:0]   rows_max;
    logic [CmpW-1:0]   rows_eff;
    logic [15:0]       mag;
    logic              is_last;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // clamp the row count into 1..MAX_ROWS
    always_comb begin
        rows_ext = CmpW'(i_rows);
        rows_max = CmpW'(MAX_ROWS);
        priority if (rows_ext == '0) begin
            rows_eff = CmpW'(1);
        end else if (rows_ext > rows_max) begin
            rows_eff = rows_max;
        end else begin
            rows_eff = rows_ext;
        end
    end

    assign pos_inc = r_pos + ROWS_W'(1);
    assign is_last = (pos_inc == '0) || (CmpW'(pos_inc) >= rows_eff);
    assign n_pos   = is_last ? '0 : pos_inc;

    // most negative sample wraps to magnitude zero
    assign mag = i_sample[15] ? (16'd0 - i_sample) : i_sample;

    always_comb begin
        o_entry.hi     = (mag[15:8] & MAG_HI_MASK) | (i_sample[15] ? SIGN_BIT : HDR_ZERO);
        o_entry.lo     = mag[7:0];
        o_entry.column = i_column;
        o_entry.first  = (r_pos == '0);
        o_entry.last   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

// ===== rtl/core/epr_queue.sv =====
// short request queue between front and back end
module epr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  epr_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output epr_pkg::t_entry o_entry
);
    import epr_pkg::*;

    localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CntW = $clog2(Q_DEPTH + 1);

    t_entry            r_mem [Q_DEPTH];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CntW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(Q_DEPTH - 1)) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(Q_DEPTH - 1)) ? '0 : r_rd + PtrW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/epr_back.sv =====
// back end: byte sequencer for header, sample bytes and checksum
module epr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  epr_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);
    import epr_pkg::*;

    typedef enum logic [2:0] {
        S_HEAD = 3'b001,
        S_DATA = 3'b010,
        S_SUM  = 3'b100
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    logic [31:0] r_sum;
    logic [31:0] n_sum;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        step_pop;
    logic        load;
    logic        go;

    assign load    = !r_out_valid || i_ready;
    assign go      = load && i_q_valid;
    assign o_pop   = go && step_pop;
    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_sum    = r_sum;
        cur_byte = HDR_ZERO;
        cur_last = 1'b0;
        step_pop = 1'b0;
        unique case (r_state)
            S_HEAD: begin
                if (i_entry.first) begin
                    unique case (r_idx)
                        3'd0:       cur_byte = HDR_SYNC;
                        3'd2, 3'd4: cur_byte = i_entry.column[15:8];
                        3'd3, 3'd5: cur_byte = i_entry.column[7:0];
                        default:    cur_byte = HDR_ZERO;
                    endcase
                    // record sum restarts with the sync byte
                    n_sum = (r_idx == 3'd0) ? 32'(cur_byte) : r_sum + 32'(cur_byte);
                    if (r_idx == 3'd7) begin
                        n_state = S_DATA;
                        n_idx   = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end else begin
                    // no header: high byte goes out at once
                    cur_byte = i_entry.hi;
                    n_sum    = r_sum + 32'(cur_byte);
                    n_state  = S_DATA;
                    n_idx    = 3'd1;
                end
            end
            S_DATA: begin
                cur_byte = r_idx[0] ? i_entry.lo : i_entry.hi;
                n_sum    = r_sum + 32'(cur_byte);
                if (r_idx[0]) begin
                    n_idx = 3'd0;
                    if (i_entry.last) begin
                        n_state = S_SUM;
                    end else begin
                        n_state  = S_HEAD;
                        step_pop = 1'b1;
                    end
                end else begin
                    n_idx = 3'd1;
                end
            end
            S_SUM: begin
                unique case (r_idx[1:0])
                    2'd0: cur_byte = r_sum[31:24];
                    2'd1: cur_byte = r_sum[23:16];
                    2'd2: cur_byte = r_sum[15:8];
                    2'd3: cur_byte = r_sum[7:0];
                endcase
                if (r_idx[1:0] == 2'd3) begin
                    cur_last = 1'b1;
                    step_pop = 1'b1;
                    n_state  = S_HEAD;
                    n_idx    = 3'd0;
                    n_sum    = '0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            default: begin
                n_state = S_HEAD;
                n_idx   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HEAD;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= go;
            end
            if (go) begin
                r_state <= n_state;
                r_idx   <= n_idx;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte <= cur_byte;
            r_out_last <= cur_last;
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench of the elevation profile record framer
module tb_top;
    import epr_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_ITEMS   = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [PADDR_W-1:0] ROWS_ADDR = {REG_ROWS_IN_USE, 2'b00};

    // predicts the framed byte stream and checks the bytes that leave the block
    class profile_scoreboard;
        typedef struct packed {
            logic [7:0] value;
            logic       last;
        } framed_byte_t;

        logic [12:0]  rows_reg;
        logic [12:0]  position;
        logic [31:0]  byte_sum;
        framed_byte_t expected_bytes[$];
        int           errors;

        function new();
            rows_reg = 13'(ROWS_RESET);
            position = '0;
            byte_sum = '0;
            errors   = 0;
        endfunction

        function void set_rows(logic [12:0] v);
            rows_reg = v;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] b, logic last, logic summed);
            framed_byte_t fb;
            fb.value = b;
            fb.last  = last;
            expected_bytes.push_back(fb);
            if (summed)
                byte_sum += 32'(b);
        endfunction

        function void note_sample(logic [15:0] smp, logic [15:0] col);
            logic [12:0] limit;
            logic [15:0] mag;
            logic [31:0] total;
            if (rows_reg == 13'd0)
                limit = 13'd1;
            else if (rows_reg > 13'(MAX_ROWS_DEF))
                limit = 13'(MAX_ROWS_DEF);
            else
                limit = rows_reg;
            if (position == 13'd0) begin
                byte_sum = '0;
                push_byte(HDR_SYNC, 1'b0, 1'b1);
                push_byte(HDR_ZERO, 1'b0, 1'b1);
                push_byte(col[15:8], 1'b0, 1'b1);
                push_byte(col[7:0], 1'b0, 1'b1);
                push_byte(col[15:8], 1'b0, 1'b1);
                push_byte(col[7:0], 1'b0, 1'b1);
                push_byte(HDR_ZERO, 1'b0, 1'b1);
                push_byte(HDR_ZERO, 1'b0, 1'b1);
            end
            // most negative sample wraps to magnitude zero with the sign set
            mag = smp[15] ? (16'h0000 - smp) : smp;
            push_byte({smp[15], mag[14:8]}, 1'b0, 1'b1);
            push_byte(mag[7:0], 1'b0, 1'b1);
            position = position + 13'd1;
            // a row count lowered mid-profile ends the record at once
            if (position >= limit || position == 13'd0) begin
                total = byte_sum;
                push_byte(total[31:24], 1'b0, 1'b0);
                push_byte(total[23:16], 1'b0, 1'b0);
                push_byte(total[15:8], 1'b0, 1'b0);
                push_byte(total[7:0], 1'b1, 1'b0);
                position = '0;
                byte_sum = '0;
            end
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            framed_byte_t fb;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: no byte expected, got %h (last_byte %b)", b, last);
                errors++;
                return;
            end
            fb = expected_bytes.pop_front();
            if (b !== fb.value) begin
                $error("out_byte: expected %h, actual %h", fb.value, b);
                errors++;
            end
            if (last !== fb.last) begin
                $error("last_byte: expected %b, actual %b", fb.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_valid  = 1'b0;
    logic [31:0] s_data   = '0;
    logic        m_ready  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    wire         s_ready;
    wire         m_valid;
    wire [7:0]   m_data;
    wire         m_last;
    wire [31:0]  prdata;
    wire         pready;

    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;
    int cycle_count = 0;

    profile_scoreboard record_sb = new();

    elevation_profile_record_framer i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[elevation_profile_record_framer] ERROR");
            $finish;
        end
    end

    // receiver drops ready with a chance of one in ten unless in a calm stretch
    always @(posedge clk) begin
        m_ready <= out_calm ? 1'b1 : ($urandom_range(99) >= 10);
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            record_sb.check_byte(m_data, m_last);
    end

    task automatic send_sample(input logic [15:0] smp, input logic [15:0] col);
        if (!in_calm) begin
            while ($urandom_range(99) < 10) begin
                s_valid <= 1'b0;
                @(posedge clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= {col, smp};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        record_sb.note_sample(smp, col);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (record_sb.pending() != 0) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ROWS_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_rows(input logic [12:0] v);
        logic [31:0] rd;
        apb_access(1'b1, {19'd0, v}, rd);
        record_sb.set_rows(v);
        apb_access(1'b0, 32'd0, rd);
        if (rd !== {19'd0, v}) begin
            $error("rows_in_use: expected %h, actual %h", {19'd0, v}, rd);
            record_sb.errors++;
        end
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom_range(16'hffff));
        endcase
    endfunction

    initial begin
        logic [31:0] rd;
        logic [12:0] rows;
        int          random_items;
        int          phase;
        int          count;
        int          limit;
        random_items = 0;
        phase        = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, 32'd0, rd);
        if (rd !== 32'(ROWS_RESET)) begin
            $error("rows_in_use: expected %h, actual %h", 32'(ROWS_RESET), rd);
            record_sb.errors++;
        end

        // extremes under the reset row count, column ignored after the first sample
        send_sample(16'h7fff, 16'hffff);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'hffff, 16'h1234);
        send_sample(16'h0000, 16'hffff);
        // row count dropped below the position ends the record on the next sample
        drain_results();
        write_rows(13'd2);
        send_sample(16'h0001, 16'h5555);
        // zero rows acts as one: every sample is a whole record
        drain_results();
        write_rows(13'd0);
        send_sample(16'h8001, 16'ha5a5);
        send_sample(16'h00ff, 16'h5a5a);
        send_sample(16'h0100, 16'h00ff);
        send_sample(16'h8000, 16'hff00);
        drain_results();
        write_rows(13'd3);
        send_sample(16'hff00, 16'h0f0f);
        send_sample(16'h8000, 16'hf0f0);
        send_sample(16'h7fff, 16'h0000);

        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0:       rows = 13'd0;
                1:       rows = 13'd1;
                7:       rows = 13'($urandom_range(40, 9));
                default: rows = 13'($urandom_range(8, 2));
            endcase
            drain_results();
            write_rows(rows);
            in_calm  = (phase == 3 || phase == 4);
            out_calm = (phase == 4 || phase == 5);
            limit = (rows == 13'd0) ? 1 : int'(rows);
            count = limit * $urandom_range(3, 1) + $urandom_range(2);
            for (int n = 0; n < count; n++) begin
                // sender holds off until the block has emptied once
                if (phase == 2 && n == count / 2)
                    drain_results();
                send_sample(random_sample(), 16'($urandom));
                random_items++;
            end
            phase++;
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;

        // largest register value is clamped, so a long profile stays open
        drain_results();
        write_rows(13'h1fff);
        for (int n = 0; n < LONG_ITEMS; n++)
            send_sample(random_sample(), 16'($urandom));

        drain_results();
        repeat (20) @(posedge clk);
        if (record_sb.errors == 0 && record_sb.pending() == 0)
            $display("[elevation_profile_record_framer] OK");
        else
            $display("[elevation_profile_record_framer] ERROR");
        $finish;
    end
endmodule
